// ----- rtl/core/lbs_pkg.sv -----
// shared types, constants and helpers of the labelled blob statistics block
package lbs_pkg;

   localparam int MAX_LABELS    = 64;
   localparam int LABEL_BITS    = $clog2(MAX_LABELS);
   localparam int MAX_COLUMNS   = 1024;
   localparam int MAX_ROWS      = 1024;
   localparam int MAX_PLANES    = 16;
   localparam int FRACTION_BITS = 8;

   localparam int COORD_BITS  = 10;
   localparam int PLANE_BITS  = 4;
   localparam int DIM_BITS    = 11;
   localparam int COUNT_BITS  = 25;
   localparam int SUM_BITS    = 34;
   localparam int PSUM_BITS   = 28;
   localparam int FIX_BITS    = 18;
   localparam int CPLANE_BITS = 12;
   localparam int OUT_LABEL_BITS = 7;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 25;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMN_COUNT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_COUNT    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_COUNT  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SIZE     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SIZE     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_RADIUS   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_RADIUS   = 3'd6;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [SUM_BITS-1:0]   column_sum;
      logic [SUM_BITS-1:0]   row_sum;
      logic [PSUM_BITS-1:0]  plane_sum;
      logic [COORD_BITS-1:0] least_column;
      logic [COORD_BITS-1:0] greatest_column;
      logic [COORD_BITS-1:0] least_row;
      logic [COORD_BITS-1:0] greatest_row;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{
      count: '0, column_sum: '0, row_sum: '0, plane_sum: '0,
      least_column: '1, greatest_column: '0, least_row: '1, greatest_row: '0};

   typedef struct packed {
      logic [OUT_LABEL_BITS-1:0] component_label;
      logic [COUNT_BITS-1:0]     pixel_count;
      logic [FIX_BITS-1:0]       centroid_column;
      logic [FIX_BITS-1:0]       centroid_row;
      logic [CPLANE_BITS-1:0]    centroid_plane;
      logic [COORD_BITS-1:0]     least_column;
      logic [COORD_BITS-1:0]     greatest_column;
      logic [COORD_BITS-1:0]     least_row;
      logic [COORD_BITS-1:0]     greatest_row;
      logic [FIX_BITS-1:0]       bound_radius;
      logic                      final_report;
      logic                      label_overflow;
   } result_type;

   typedef struct packed {
      logic                  start;
      logic [SUM_BITS-1:0]   dividend;
      logic [COUNT_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [FIX_BITS-1:0] quotient;
   } div_rsp_type;

   // zero counts as one, anything above the limit saturates
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] value,
                                                     input logic [DIM_BITS-1:0] limit);
      logic [DIM_BITS-1:0] r;
      if (value == '0) begin
         r = DIM_BITS'(1);
      end else if (value > limit) begin
         r = limit;
      end else begin
         r = value;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/lbs_table.sv -----
// per-label statistics memory with valid bits so that one clear empties every entry
module lbs_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic                           rd_en,
   input  logic [lbs_pkg::LABEL_BITS-1:0] rd_addr,
   output lbs_pkg::entry_type             rd_data,
   input  logic                           wr_en,
   input  logic [lbs_pkg::LABEL_BITS-1:0] wr_addr,
   input  lbs_pkg::entry_type             wr_data
);

   lbs_pkg::entry_type mem [lbs_pkg::MAX_LABELS];
   lbs_pkg::entry_type q_ff;
   logic [lbs_pkg::MAX_LABELS-1:0] valid_ff;
   logic [lbs_pkg::MAX_LABELS-1:0] valid_in;
   logic q_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            q_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written since the last clear reads as empty
   assign rd_data = q_valid_ff ? q_ff : lbs_pkg::EMPTY_ENTRY;

endmodule

// ----- rtl/core/lbs_divider.sv -----
// bit-serial restoring divider for the fixed-point centroids
module lbs_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  lbs_pkg::div_req_type req,
   output lbs_pkg::div_rsp_type rsp
);

   localparam int REM_BITS = lbs_pkg::COUNT_BITS;
   localparam int HI_LSB   = lbs_pkg::FIX_BITS - lbs_pkg::FRACTION_BITS;
   localparam int CNT_BITS = $clog2(lbs_pkg::FIX_BITS + 1);

   logic [REM_BITS-1:0]              rem_ff;
   logic [lbs_pkg::FIX_BITS-1:0]     sh_ff;
   logic [lbs_pkg::COUNT_BITS-1:0]   den_ff;
   logic [CNT_BITS-1:0]              cnt_ff;
   logic                             busy_ff;
   logic                             done_ff;
   logic [REM_BITS:0]                trial;
   logic                             fits;
   logic [REM_BITS:0]                diff;

   assign trial = {rem_ff, sh_ff[lbs_pkg::FIX_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (req.start) begin
         // quotient fits the fixed-point width: the high part is already below the divisor
         rem_ff <= REM_BITS'(req.dividend[lbs_pkg::SUM_BITS-1:HI_LSB]);
         sh_ff  <= {req.dividend[HI_LSB-1:0], {lbs_pkg::FRACTION_BITS{1'b0}}};
         den_ff <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
         sh_ff  <= {sh_ff[lbs_pkg::FIX_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(lbs_pkg::FIX_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = sh_ff;

endmodule

// ----- rtl/core/labelled_blob_statistics.sv -----
// labelled blob statistics top level: pixel accumulation and report sequencer
//
//  channel | direction | words
//  req_    | in        | one pixel label per word, raster order
//  rsp_    | out       | one word per reported component
//  csr_    | in        | register index and data, always ready
//
// a labelled pixel passes a table read, then a read-modify-write;
// a background or out-of-range pixel needs only its accept.
// after the last pixel each label up to the highest seen goes through a
// table read, three divisions on the shared divider, 4 radius steps
// and the window check; empty labels skip from the table read to the next label.
// synchronous reset clears control state and all table valid bits at once.
// a held result word stalls the report loop when a newer word must pass it, and at the flush
module labelled_blob_statistics (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [15:0]                        req_label_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lbs_pkg::OUT_LABEL_BITS-1:0] rsp_component_label,
   output logic [lbs_pkg::COUNT_BITS-1:0]     rsp_pixel_count,
   output logic [lbs_pkg::FIX_BITS-1:0]       rsp_centroid_column,
   output logic [lbs_pkg::FIX_BITS-1:0]       rsp_centroid_row,
   output logic [lbs_pkg::CPLANE_BITS-1:0]    rsp_centroid_plane,
   output logic [lbs_pkg::COORD_BITS-1:0]     rsp_least_column,
   output logic [lbs_pkg::COORD_BITS-1:0]     rsp_greatest_column,
   output logic [lbs_pkg::COORD_BITS-1:0]     rsp_least_row,
   output logic [lbs_pkg::COORD_BITS-1:0]     rsp_greatest_row,
   output logic [lbs_pkg::FIX_BITS-1:0]       rsp_bound_radius,
   output logic                               rsp_final_report,
   output logic                               rsp_label_overflow,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lbs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lbs_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int LB  = lbs_pkg::LABEL_BITS;
   localparam int OLB = lbs_pkg::OUT_LABEL_BITS;
   localparam int CB  = lbs_pkg::COORD_BITS;
   localparam int PB  = lbs_pkg::PLANE_BITS;
   localparam int DB  = lbs_pkg::DIM_BITS;
   localparam int FB  = lbs_pkg::FIX_BITS;
   localparam int FR  = lbs_pkg::FRACTION_BITS;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_UPD   = 9'b000000010,
      ST_RREAD = 9'b000000100,
      ST_RLAT  = 9'b000001000,
      ST_DIV   = 9'b000010000,
      ST_RAD   = 9'b000100000,
      ST_FILT  = 9'b001000000,
      ST_NEXT  = 9'b010000000,
      ST_FLUSH = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [DB-1:0]                   column_count_ff;
   logic [DB-1:0]                   row_count_ff;
   logic [4:0]                      plane_count_ff;
   logic [lbs_pkg::COUNT_BITS-1:0]  min_size_ff;
   logic [lbs_pkg::COUNT_BITS-1:0]  max_size_ff;
   logic [FB-1:0]                   min_radius_ff;
   logic [FB-1:0]                   max_radius_ff;

   // scan position and volume flags
   logic [CB-1:0]  col_ff;
   logic [CB-1:0]  row_ff;
   logic [PB-1:0]  pln_ff;
   logic [OLB-1:0] highest_ff;
   logic           overflow_ff;

   // pixel under update
   logic [LB-1:0] pix_idx_ff;
   logic [CB-1:0] pix_col_ff;
   logic [CB-1:0] pix_row_ff;
   logic [PB-1:0] pix_pln_ff;
   logic          end_ff;

   // report loop
   logic [OLB-1:0]           k_ff;
   lbs_pkg::entry_type       ent_ff;
   logic [1:0]               op_ff;
   logic                     go_ff;
   logic [FB-1:0]            cc_ff;
   logic [FB-1:0]            cr_ff;
   logic [lbs_pkg::CPLANE_BITS-1:0] cp_ff;
   logic [1:0]               rstep_ff;
   logic [FB-1:0]            radius_ff;
   lbs_pkg::result_type      pend_ff;
   logic                     pend_valid_ff;
   lbs_pkg::result_type      out_ff;
   logic                     out_valid_ff;

   logic [DB-1:0] ncol, nrow, npln;
   logic          col_end, row_end, pln_end;
   logic          accept;
   logic          label_ok;
   logic [LB-1:0] label_idx;

   logic                 tbl_rd_en;
   logic [LB-1:0]        tbl_rd_addr;
   lbs_pkg::entry_type   tbl_rd_data;
   logic                 tbl_wr_en;
   lbs_pkg::entry_type   upd_entry;
   logic                 tbl_clear;

   lbs_pkg::div_req_type div_req;
   lbs_pkg::div_rsp_type div_rsp;

   logic [FB-1:0] rad_center;
   logic [FB-1:0] rad_bound;
   logic [FB-1:0] rad_dist;
   logic          pass;
   logic          can_push;
   logic          load_out;
   lbs_pkg::result_type cand;
   lbs_pkg::result_type last_word;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   assign ncol = lbs_pkg::clamp_dim(column_count_ff, DB'(lbs_pkg::MAX_COLUMNS));
   assign nrow = lbs_pkg::clamp_dim(row_count_ff, DB'(lbs_pkg::MAX_ROWS));
   assign npln = lbs_pkg::clamp_dim(DB'(plane_count_ff), DB'(lbs_pkg::MAX_PLANES));

   // a position at or past a lowered dimension ends that dimension
   assign col_end = (DB'(col_ff) + DB'(1)) >= ncol;
   assign row_end = (DB'(row_ff) + DB'(1)) >= nrow;
   assign pln_end = (DB'(pln_ff) + DB'(1)) >= npln;

   assign label_ok  = (req_label_value != 16'd0) &&
                      (req_label_value <= 16'(lbs_pkg::MAX_LABELS));
   assign label_idx = LB'(req_label_value - 16'd1);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= DB'(lbs_pkg::MAX_COLUMNS);
         row_count_ff    <= DB'(lbs_pkg::MAX_ROWS);
         plane_count_ff  <= 5'd1;
         min_size_ff     <= '0;
         max_size_ff     <= lbs_pkg::COUNT_BITS'(16777216);
         min_radius_ff   <= '0;
         max_radius_ff   <= '1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lbs_pkg::CSR_COLUMN_COUNT: column_count_ff <= csr_data[DB-1:0];
            lbs_pkg::CSR_ROW_COUNT:    row_count_ff    <= csr_data[DB-1:0];
            lbs_pkg::CSR_PLANE_COUNT:  plane_count_ff  <= csr_data[4:0];
            lbs_pkg::CSR_MIN_SIZE:     min_size_ff     <= csr_data;
            lbs_pkg::CSR_MAX_SIZE:     max_size_ff     <= csr_data;
            lbs_pkg::CSR_MIN_RADIUS:   min_radius_ff   <= csr_data[FB-1:0];
            lbs_pkg::CSR_MAX_RADIUS:   max_radius_ff   <= csr_data[FB-1:0];
            default: ;
         endcase
      end
   end

   // table: read on accept of a labelled pixel or in the report loop, write in the update cycle
   assign tbl_rd_en   = (accept && label_ok) || (state_ff == ST_RREAD);
   assign tbl_rd_addr = (state_ff == ST_RREAD) ? LB'(k_ff - OLB'(1)) : label_idx;
   assign tbl_wr_en   = (state_ff == ST_UPD);
   assign tbl_clear   = (state_ff == ST_FLUSH) && (!pend_valid_ff || can_push);

   always_comb begin
      upd_entry            = tbl_rd_data;
      upd_entry.count      = tbl_rd_data.count + lbs_pkg::COUNT_BITS'(1);
      upd_entry.column_sum = tbl_rd_data.column_sum + lbs_pkg::SUM_BITS'(pix_col_ff);
      upd_entry.row_sum    = tbl_rd_data.row_sum + lbs_pkg::SUM_BITS'(pix_row_ff);
      upd_entry.plane_sum  = tbl_rd_data.plane_sum + lbs_pkg::PSUM_BITS'(pix_pln_ff);
      if (pix_col_ff < tbl_rd_data.least_column) upd_entry.least_column = pix_col_ff;
      if (pix_col_ff > tbl_rd_data.greatest_column) upd_entry.greatest_column = pix_col_ff;
      if (pix_row_ff < tbl_rd_data.least_row) upd_entry.least_row = pix_row_ff;
      if (pix_row_ff > tbl_rd_data.greatest_row) upd_entry.greatest_row = pix_row_ff;
   end

   lbs_table u_table (
      .clock   (clock),
      .reset   (reset),
      .clear   (tbl_clear),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data),
      .wr_en   (tbl_wr_en),
      .wr_addr (pix_idx_ff),
      .wr_data (upd_entry)
   );

   // shared divider: column, row, then plane sum over the count
   always_comb begin
      div_req.start   = go_ff;
      div_req.divisor = ent_ff.count;
      case (op_ff)
         2'd0:    div_req.dividend = ent_ff.column_sum;
         2'd1:    div_req.dividend = ent_ff.row_sum;
         default: div_req.dividend = lbs_pkg::SUM_BITS'(ent_ff.plane_sum);
      endcase
   end

   lbs_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // one distance per radius step
   always_comb begin
      rad_center = rstep_ff[1] ? cr_ff : cc_ff;
      case (rstep_ff)
         2'd0:    rad_bound = {ent_ff.least_column, {FR{1'b0}}};
         2'd1:    rad_bound = {ent_ff.greatest_column, {FR{1'b0}}};
         2'd2:    rad_bound = {ent_ff.least_row, {FR{1'b0}}};
         default: rad_bound = {ent_ff.greatest_row, {FR{1'b0}}};
      endcase
      rad_dist = (rad_center > rad_bound) ? rad_center - rad_bound : rad_bound - rad_center;
   end

   assign pass = (ent_ff.count >= min_size_ff) && (ent_ff.count <= max_size_ff) &&
                 (radius_ff >= min_radius_ff) && (radius_ff <= max_radius_ff);
   assign can_push = !out_valid_ff || rsp_ready;

   // the held word moves to the output when a newer one passes it or at the flush
   assign load_out = pend_valid_ff && can_push &&
                     (((state_ff == ST_FILT) && pass) || (state_ff == ST_FLUSH));

   always_comb begin
      cand.component_label = k_ff;
      cand.pixel_count     = ent_ff.count;
      cand.centroid_column = cc_ff;
      cand.centroid_row    = cr_ff;
      cand.centroid_plane  = cp_ff;
      cand.least_column    = ent_ff.least_column;
      cand.greatest_column = ent_ff.greatest_column;
      cand.least_row       = ent_ff.least_row;
      cand.greatest_row    = ent_ff.greatest_row;
      cand.bound_radius    = radius_ff;
      cand.final_report    = 1'b0;
      cand.label_overflow  = overflow_ff;
   end

   // the word left over at the flush closes the volume
   always_comb begin
      last_word              = pend_ff;
      last_word.final_report = 1'b1;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (label_ok) begin
                  state_in = ST_UPD;
               end else if (col_end && row_end && pln_end) begin
                  state_in = (highest_ff != '0) ? ST_RREAD : ST_FLUSH;
               end
            end
         end
         ST_UPD: begin
            if (end_ff) begin
               state_in = (highest_ff != '0) ? ST_RREAD : ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RREAD: state_in = ST_RLAT;
         ST_RLAT:  state_in = (tbl_rd_data.count == '0) ? ST_NEXT : ST_DIV;
         ST_DIV: begin
            if (div_rsp.done && op_ff == 2'd2) state_in = ST_RAD;
         end
         ST_RAD: begin
            if (rstep_ff == 2'd3) state_in = ST_FILT;
         end
         ST_FILT: begin
            if (!pass || !pend_valid_ff || can_push) state_in = ST_NEXT;
         end
         ST_NEXT:  state_in = (k_ff == highest_ff) ? ST_FLUSH : ST_RREAD;
         ST_FLUSH: begin
            if (!pend_valid_ff || can_push) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // divider start: first operand after the table read, the next two after each quotient
   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         go_ff <= ((state_ff == ST_RLAT) && (tbl_rd_data.count != '0)) ||
                  ((state_ff == ST_DIV) && div_rsp.done && (op_ff != 2'd2));
         out_valid_ff <= load_out || (out_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         row_ff        <= '0;
         pln_ff        <= '0;
         highest_ff    <= '0;
         overflow_ff   <= 1'b0;
         end_ff        <= 1'b0;
         k_ff          <= '0;
         op_ff         <= '0;
         rstep_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  end_ff <= col_end && row_end && pln_end;
                  if (!label_ok && req_label_value != 16'd0) overflow_ff <= 1'b1;
                  if (label_ok && OLB'(req_label_value) > highest_ff) begin
                     highest_ff <= OLB'(req_label_value);
                  end
                  // column fastest, then row, then plane
                  if (!col_end) begin
                     col_ff <= col_ff + CB'(1);
                  end else begin
                     col_ff <= '0;
                     if (!row_end) begin
                        row_ff <= row_ff + CB'(1);
                     end else begin
                        row_ff <= '0;
                        pln_ff <= pln_end ? '0 : pln_ff + PB'(1);
                     end
                  end
                  k_ff <= OLB'(1);
               end
            end
            ST_RLAT: begin
               op_ff <= '0;
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  if (op_ff != 2'd2) begin
                     op_ff <= op_ff + 2'd1;
                  end
                  rstep_ff <= '0;
               end
            end
            ST_RAD: rstep_ff <= rstep_ff + 2'd1;
            ST_FILT: begin
               if (pass && !pend_valid_ff) begin
                  pend_valid_ff <= 1'b1;
               end
            end
            ST_NEXT: k_ff <= k_ff + OLB'(1);
            ST_FLUSH: begin
               if (!pend_valid_ff || can_push) begin
                  pend_valid_ff <= 1'b0;
                  highest_ff    <= '0;
                  overflow_ff   <= 1'b0;
                  col_ff        <= '0;
                  row_ff        <= '0;
                  pln_ff        <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_idx_ff <= label_idx;
         pix_col_ff <= col_ff;
         pix_row_ff <= row_ff;
         pix_pln_ff <= pln_ff;
      end
      if (state_ff == ST_RLAT) ent_ff <= tbl_rd_data;
      if (state_ff == ST_DIV && div_rsp.done) begin
         case (op_ff)
            2'd0:    cc_ff <= div_rsp.quotient;
            2'd1:    cr_ff <= div_rsp.quotient;
            default: cp_ff <= div_rsp.quotient[lbs_pkg::CPLANE_BITS-1:0];
         endcase
      end
      if (state_ff == ST_RAD) begin
         if (rstep_ff == 2'd0 || rad_dist > radius_ff) radius_ff <= rad_dist;
      end
      if (state_ff == ST_FILT && pass) begin
         if (!pend_valid_ff) begin
            pend_ff <= cand;
         end else if (can_push) begin
            out_ff  <= pend_ff;
            pend_ff <= cand;
         end
      end
      if (state_ff == ST_FLUSH && pend_valid_ff && can_push) begin
         out_ff <= last_word;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_component_label = out_ff.component_label;
   assign rsp_pixel_count     = out_ff.pixel_count;
   assign rsp_centroid_column = out_ff.centroid_column;
   assign rsp_centroid_row    = out_ff.centroid_row;
   assign rsp_centroid_plane  = out_ff.centroid_plane;
   assign rsp_least_column    = out_ff.least_column;
   assign rsp_greatest_column = out_ff.greatest_column;
   assign rsp_least_row       = out_ff.least_row;
   assign rsp_greatest_row    = out_ff.greatest_row;
   assign rsp_bound_radius    = out_ff.bound_radius;
   assign rsp_final_report    = out_ff.final_report;
   assign rsp_label_overflow  = out_ff.label_overflow;

endmodule

// ----- sim/labelled_blob_statistics_tb.sv -----
// self-checking testbench of the labelled blob statistics block
module labelled_blob_statistics_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // the settle wait covers a report scan of all 64 labels
   localparam int SCAN_CYCLES = 4600;
   // register index past the end of the list
   localparam logic [lbs_pkg::CSR_INDEX_BITS-1:0] UNMAPPED_INDEX = 3'd7;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [15:0] req_label_value;
   logic rsp_valid;
   logic rsp_ready;
   logic [lbs_pkg::OUT_LABEL_BITS-1:0] rsp_component_label;
   logic [lbs_pkg::COUNT_BITS-1:0] rsp_pixel_count;
   logic [lbs_pkg::FIX_BITS-1:0] rsp_centroid_column;
   logic [lbs_pkg::FIX_BITS-1:0] rsp_centroid_row;
   logic [lbs_pkg::CPLANE_BITS-1:0] rsp_centroid_plane;
   logic [lbs_pkg::COORD_BITS-1:0] rsp_least_column;
   logic [lbs_pkg::COORD_BITS-1:0] rsp_greatest_column;
   logic [lbs_pkg::COORD_BITS-1:0] rsp_least_row;
   logic [lbs_pkg::COORD_BITS-1:0] rsp_greatest_row;
   logic [lbs_pkg::FIX_BITS-1:0] rsp_bound_radius;
   logic rsp_final_report;
   logic rsp_label_overflow;
   logic csr_valid;
   logic csr_ready;
   logic [lbs_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [lbs_pkg::CSR_DATA_BITS-1:0] csr_data;

   labelled_blob_statistics u_top (.*);

   // idle percentages of sender and receiver, and a forced receiver hold-off
   int send_idle_pct;
   int stall_pct;
   int hold_cycles;
   int mismatch_count;

   // expected report words, oldest first
   lbs_pkg::result_type blob_reports[$];

   // predictor copy of registers and per-label accumulators
   logic [lbs_pkg::CSR_DATA_BITS-1:0] csr_shadow[7];
   longint unsigned pix_count[lbs_pkg::MAX_LABELS];
   longint unsigned col_sum[lbs_pkg::MAX_LABELS];
   longint unsigned row_sum[lbs_pkg::MAX_LABELS];
   longint unsigned pln_sum[lbs_pkg::MAX_LABELS];
   int unsigned lo_col[lbs_pkg::MAX_LABELS];
   int unsigned hi_col[lbs_pkg::MAX_LABELS];
   int unsigned lo_row[lbs_pkg::MAX_LABELS];
   int unsigned hi_row[lbs_pkg::MAX_LABELS];
   int unsigned top_label;
   int unsigned col_pos;
   int unsigned row_pos;
   int unsigned pln_pos;
   bit overflow_flag;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Verification failed");
      $finish;
   end

   task automatic clear_blobs();
      for (int i = 0; i < lbs_pkg::MAX_LABELS; i++) begin
         pix_count[i] = 0;
         col_sum[i] = 0;
         row_sum[i] = 0;
         pln_sum[i] = 0;
         lo_col[i] = 1023;
         hi_col[i] = 0;
         lo_row[i] = 1023;
         hi_row[i] = 0;
      end
      top_label = 0;
      col_pos = 0;
      row_pos = 0;
      pln_pos = 0;
      overflow_flag = 1'b0;
   endtask

   function automatic int unsigned dim_of(logic [lbs_pkg::CSR_DATA_BITS-1:0] r,
                                          int unsigned limit);
      if (r == 0) return 1;
      if (r > limit) return limit;
      return 32'(r);
   endfunction

   function automatic longint unsigned gap(longint unsigned a, longint unsigned b);
      return a > b ? a - b : b - a;
   endfunction

   // accumulate one pixel; on the last pixel of the volume queue its reports
   task automatic accumulate_pixel(input logic [15:0] lbl);
      int unsigned ncol, nrow, npln, s;
      longint unsigned n, cc, cr, cp, rad;
      lbs_pkg::result_type w;
      int last_idx;
      ncol = dim_of(csr_shadow[lbs_pkg::CSR_COLUMN_COUNT], lbs_pkg::MAX_COLUMNS);
      nrow = dim_of(csr_shadow[lbs_pkg::CSR_ROW_COUNT], lbs_pkg::MAX_ROWS);
      npln = dim_of(csr_shadow[lbs_pkg::CSR_PLANE_COUNT], lbs_pkg::MAX_PLANES);
      if (lbl > lbs_pkg::MAX_LABELS) begin
         overflow_flag = 1'b1;
      end else if (lbl != 0) begin
         s = 32'(lbl) - 1;
         pix_count[s]++;
         col_sum[s] += col_pos;
         row_sum[s] += row_pos;
         pln_sum[s] += pln_pos;
         if (col_pos < lo_col[s]) lo_col[s] = col_pos;
         if (col_pos > hi_col[s]) hi_col[s] = col_pos;
         if (row_pos < lo_row[s]) lo_row[s] = row_pos;
         if (row_pos > hi_row[s]) hi_row[s] = row_pos;
         if (lbl > top_label) top_label = 32'(lbl);
      end
      // positions at or past a lowered dimension count as its last index
      if (col_pos + 1 < ncol) begin
         col_pos++;
         return;
      end
      col_pos = 0;
      if (row_pos + 1 < nrow) begin
         row_pos++;
         return;
      end
      row_pos = 0;
      if (pln_pos + 1 < npln) begin
         pln_pos++;
         return;
      end
      last_idx = -1;
      for (int k = 1; k <= top_label; k++) begin
         s = k - 1;
         n = pix_count[s];
         if (n == 0) continue;
         cc = (col_sum[s] << lbs_pkg::FRACTION_BITS) / n;
         cr = (row_sum[s] << lbs_pkg::FRACTION_BITS) / n;
         cp = (pln_sum[s] << lbs_pkg::FRACTION_BITS) / n;
         rad = gap(cc, longint'(lo_col[s]) << lbs_pkg::FRACTION_BITS);
         if (gap(cc, longint'(hi_col[s]) << lbs_pkg::FRACTION_BITS) > rad)
            rad = gap(cc, longint'(hi_col[s]) << lbs_pkg::FRACTION_BITS);
         if (gap(cr, longint'(lo_row[s]) << lbs_pkg::FRACTION_BITS) > rad)
            rad = gap(cr, longint'(lo_row[s]) << lbs_pkg::FRACTION_BITS);
         if (gap(cr, longint'(hi_row[s]) << lbs_pkg::FRACTION_BITS) > rad)
            rad = gap(cr, longint'(hi_row[s]) << lbs_pkg::FRACTION_BITS);
         if (n < csr_shadow[lbs_pkg::CSR_MIN_SIZE] ||
             n > csr_shadow[lbs_pkg::CSR_MAX_SIZE]) continue;
         if (rad < csr_shadow[lbs_pkg::CSR_MIN_RADIUS] ||
             rad > csr_shadow[lbs_pkg::CSR_MAX_RADIUS]) continue;
         w.component_label = lbs_pkg::OUT_LABEL_BITS'(k);
         w.pixel_count = lbs_pkg::COUNT_BITS'(n);
         w.centroid_column = lbs_pkg::FIX_BITS'(cc);
         w.centroid_row = lbs_pkg::FIX_BITS'(cr);
         w.centroid_plane = lbs_pkg::CPLANE_BITS'(cp);
         w.least_column = lbs_pkg::COORD_BITS'(lo_col[s]);
         w.greatest_column = lbs_pkg::COORD_BITS'(hi_col[s]);
         w.least_row = lbs_pkg::COORD_BITS'(lo_row[s]);
         w.greatest_row = lbs_pkg::COORD_BITS'(hi_row[s]);
         w.bound_radius = lbs_pkg::FIX_BITS'(rad);
         w.final_report = 1'b0;
         w.label_overflow = overflow_flag;
         blob_reports = {blob_reports, w};
         last_idx = blob_reports.size() - 1;
      end
      // the last surviving label closes the volume
      if (last_idx >= 0) blob_reports[last_idx].final_report = 1'b1;
      clear_blobs();
   endtask

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      mismatch_count++;
      $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
   endtask

   // send one pixel word with random idle cycles ahead of it
   task automatic send_label(input logic [15:0] lbl);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_label_value <= lbl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accumulate_pixel(lbl);
   endtask

   // wait until nothing is expected and the report scan has surely finished
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (blob_reports.size() == 0);
      repeat (SCAN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lbs_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [lbs_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         lbs_pkg::CSR_COLUMN_COUNT, lbs_pkg::CSR_ROW_COUNT:
            csr_shadow[idx] = value & 25'h7FF;
         lbs_pkg::CSR_PLANE_COUNT: csr_shadow[idx] = value & 25'h1F;
         lbs_pkg::CSR_MIN_SIZE, lbs_pkg::CSR_MAX_SIZE: csr_shadow[idx] = value;
         lbs_pkg::CSR_MIN_RADIUS, lbs_pkg::CSR_MAX_RADIUS:
            csr_shadow[idx] = value & 25'h3FFFF;
         default: ;  // unmapped index is dropped
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_volume(input int c, input int r, input int p);
      settle();
      write_csr(lbs_pkg::CSR_COLUMN_COUNT, lbs_pkg::CSR_DATA_BITS'(c));
      write_csr(lbs_pkg::CSR_ROW_COUNT, lbs_pkg::CSR_DATA_BITS'(r));
      write_csr(lbs_pkg::CSR_PLANE_COUNT, lbs_pkg::CSR_DATA_BITS'(p));
   endtask

   task automatic set_window(input int smin, input int smax, input int rmin, input int rmax);
      settle();
      write_csr(lbs_pkg::CSR_MIN_SIZE, lbs_pkg::CSR_DATA_BITS'(smin));
      write_csr(lbs_pkg::CSR_MAX_SIZE, lbs_pkg::CSR_DATA_BITS'(smax));
      write_csr(lbs_pkg::CSR_MIN_RADIUS, lbs_pkg::CSR_DATA_BITS'(rmin));
      write_csr(lbs_pkg::CSR_MAX_RADIUS, lbs_pkg::CSR_DATA_BITS'(rmax));
   endtask

   // one row: first, middle and last columns labelled, out-of-range and background labels between
   task automatic test_column_extremes();
      set_volume(40, 1, 1);
      for (int i = 0; i < 40; i++) begin
         case (i)
            0: send_label(16'd1);
            1: send_label(16'd65);
            2: send_label(16'hFFFF);
            20: send_label(16'd64);
            39: send_label(16'd64);
            default: send_label(16'd0);
         endcase
      end
      // zero rows and planes count as one
      set_volume(5, 0, 0);
      for (int i = 0; i < 5; i++) send_label(i == 4 ? 16'd2 : 16'd0);
   endtask

   // one column of several rows, then 16 planes of one pixel via saturation
   task automatic test_row_plane_extremes();
      set_volume(0, 24, 1);
      for (int i = 0; i < 24; i++) send_label((i == 0 || i == 23) ? 16'd3 : 16'd0);
      set_volume(1, 1, 31);
      for (int i = 0; i < 16; i++) send_label(i == 0 || i == 15 ? 16'd7 : 16'd0);
   endtask

   // empty labels, all-background volume and filtered-out volume give no report
   task automatic test_windows();
      set_volume(3, 2, 2);
      for (int i = 0; i < 12; i++) send_label(i < 6 ? 16'd5 : (i == 11 ? 16'd2 : 16'd0));
      for (int i = 0; i < 12; i++) send_label(16'd0);
      set_window(25'h1FFFFFF, 16777216, 0, 262143);
      for (int i = 0; i < 12; i++) send_label(16'd4);
      set_window(2, 5, 1, 300);
      for (int i = 0; i < 12; i++) send_label(16'(i % 4));
      set_window(0, 0, 0, 0);
      for (int i = 0; i < 12; i++) send_label(i == 3 ? 16'd9 : 16'd0);
      set_window(0, 16777216, 0, 25'h1FFFFFF);
   endtask

   // unmapped index and wide data, then a width lowered in mid-volume
   task automatic test_register_corners();
      settle();
      write_csr(UNMAPPED_INDEX, 25'h1FFFFFF);
      set_volume(11'h7FF | 25'h1FFF800, 4, 1);
      for (int i = 0; i < 10; i++) send_label(16'd6);
      settle();
      write_csr(lbs_pkg::CSR_COLUMN_COUNT, 25'd4);
      for (int i = 0; i < 12; i++) send_label(16'd6);
   endtask

   // receiver held off while volumes stream in, then sender waits for drain
   task automatic test_backpressure();
      set_volume(2, 2, 1);
      hold_cycles = 3000;
      for (int v = 0; v < 6; v++)
         for (int i = 0; i < 4; i++) send_label(16'(i + 1 + v));
      settle();
      for (int i = 0; i < 4; i++) send_label(16'd8);
   endtask

   function automatic logic [15:0] pick_label(int palette);
      int r;
      r = $urandom_range(99);
      if (r < 20) return 16'd0;
      if (r < 70) return 16'($urandom_range(palette, 1));
      if (r < 92) return 16'($urandom_range(lbs_pkg::MAX_LABELS, 1));
      if (r < 96) return 16'(lbs_pkg::MAX_LABELS + 1);
      return 16'($urandom_range(16'hFFFF, 0));
   endfunction

   task automatic run_random_volumes(input int items);
      int sent, c, r, p, palette;
      sent = 0;
      while (sent < items) begin
         c = $urandom_range(6, 1);
         r = $urandom_range(5, 1);
         p = $urandom_range(3, 1);
         set_volume(c, r, p);
         if ($urandom_range(3) == 0)
            set_window($urandom_range(3), $urandom_range(40, 2),
                       $urandom_range(200), $urandom_range(1500, 200));
         else
            set_window(0, 16777216, 0, 262143);
         palette = $urandom_range(8, 1);
         for (int i = 0; i < c * r * p; i++) begin
            send_label(pick_label(palette));
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      send_idle_pct = 32;
      stall_pct = 51;
      run_random_volumes(70);
      send_idle_pct = 51;
      stall_pct = 32;
      run_random_volumes(70);
      send_idle_pct = 0;
      stall_pct = 0;
      run_random_volumes(70);
   endtask

   // receiver: random stalls, plus forced hold-off stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // compare each accepted report word against the oldest expectation
   always @(posedge clock) begin
      lbs_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (blob_reports.size() == 0) begin
            report_mismatch("unexpected word, label", rsp_component_label, 0);
         end else begin
            want = blob_reports.pop_front();
            if (rsp_component_label != want.component_label)
               report_mismatch("component_label", rsp_component_label, want.component_label);
            if (rsp_pixel_count != want.pixel_count)
               report_mismatch("pixel_count", rsp_pixel_count, want.pixel_count);
            if (rsp_centroid_column != want.centroid_column)
               report_mismatch("centroid_column", rsp_centroid_column, want.centroid_column);
            if (rsp_centroid_row != want.centroid_row)
               report_mismatch("centroid_row", rsp_centroid_row, want.centroid_row);
            if (rsp_centroid_plane != want.centroid_plane)
               report_mismatch("centroid_plane", rsp_centroid_plane, want.centroid_plane);
            if (rsp_least_column != want.least_column)
               report_mismatch("least_column", rsp_least_column, want.least_column);
            if (rsp_greatest_column != want.greatest_column)
               report_mismatch("greatest_column", rsp_greatest_column, want.greatest_column);
            if (rsp_least_row != want.least_row)
               report_mismatch("least_row", rsp_least_row, want.least_row);
            if (rsp_greatest_row != want.greatest_row)
               report_mismatch("greatest_row", rsp_greatest_row, want.greatest_row);
            if (rsp_bound_radius != want.bound_radius)
               report_mismatch("bound_radius", rsp_bound_radius, want.bound_radius);
            if (rsp_final_report != want.final_report)
               report_mismatch("final_report", rsp_final_report, want.final_report);
            if (rsp_label_overflow != want.label_overflow)
               report_mismatch("label_overflow", rsp_label_overflow, want.label_overflow);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_label_value = '0;
      csr_valid = 1'b0;
      csr_index = lbs_pkg::CSR_COLUMN_COUNT;
      csr_data = '0;
      send_idle_pct = 32;
      stall_pct = 51;
      hold_cycles = 0;
      mismatch_count = 0;
      csr_shadow[lbs_pkg::CSR_COLUMN_COUNT] = 1024;
      csr_shadow[lbs_pkg::CSR_ROW_COUNT] = 1024;
      csr_shadow[lbs_pkg::CSR_PLANE_COUNT] = 1;
      csr_shadow[lbs_pkg::CSR_MIN_SIZE] = 0;
      csr_shadow[lbs_pkg::CSR_MAX_SIZE] = 16777216;
      csr_shadow[lbs_pkg::CSR_MIN_RADIUS] = 0;
      csr_shadow[lbs_pkg::CSR_MAX_RADIUS] = 262143;
      clear_blobs();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_column_extremes();
      test_row_plane_extremes();
      test_windows();
      test_register_corners();
      test_backpressure();
      test_random_traffic();

      settle();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
